/* src/fsp_pkg.sv */
// fsp_pkg: shared types, widths and constants of the frame skip pacer
// no dependencies; compile first

package fsp_pkg;

    // field and datapath widths
    localparam int TIME_W   = 32;
    localparam int FPS_W    = 8;
    localparam int FREQ_W   = 32;
    localparam int CNT_W    = 8;
    localparam int TOTAL_W  = CNT_W + 1;
    localparam int RATE_W   = 24;
    localparam int LOAD_W   = 16;
    localparam int DEC_W    = 2;
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ACC_W    = 58;
    localparam int NUM_W    = 52;
    localparam int DEN_W    = 40;
    localparam int DCNT_W   = $clog2(NUM_W + 1);
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    // fixed point scaling
    localparam int RATE_FRAC = 8;
    localparam int LOAD_FRAC = 12;

    // skip policy
    localparam int MAX_SKIP_RUN   = 1;
    localparam int SKIP_TOLERANCE = 2;
    localparam int RUN_W          = $clog2(MAX_SKIP_RUN + 1);

    // saturation limits and reset values
    localparam logic [RATE_W-1:0] RATE_MAX   = {RATE_W{1'b1}};
    localparam logic [LOAD_W-1:0] LOAD_MAX   = {LOAD_W{1'b1}};
    localparam logic [TIME_W-1:0] BUSY_MAX   = {TIME_W{1'b1}};
    localparam logic [LOAD_W-1:0] LOAD_RESET = 16'd4096;
    localparam logic [FPS_W-1:0]  FPS_RESET  = 8'd15;
    localparam logic [FREQ_W-1:0] FREQ_RESET = 32'd1000000;

    // idle test scale factors: (1.1 - load) * 0.5 in units of 1/81920
    localparam logic [MUL_W-1:0] K_FRAME_SCALE = 32'd81920;
    localparam logic [MUL_W-1:0] K_MARGIN      = 32'd45056;
    localparam logic [MUL_W-1:0] K_LOAD_SCALE  = 32'd10;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FPS  = 1'b0,
        CFG_FREQ = 1'b1
    } fsp_cfg_idx_t;

    // frame decisions
    typedef enum logic [DEC_W-1:0] {
        DEC_IDLE   = 2'd0,
        DEC_RENDER = 2'd1,
        DEC_SKIP   = 2'd2
    } fsp_decision_t;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } fsp_div_stat_t;

    // saturate a quotient to the rate field
    function automatic logic [RATE_W-1:0] sat_rate(input logic [NUM_W-1:0] q);
        logic [RATE_W-1:0] r;
        r = (|q[NUM_W-1:RATE_W]) ? RATE_MAX : q[RATE_W-1:0];
        return r;
    endfunction

    // saturate a quotient to the load field
    function automatic logic [LOAD_W-1:0] sat_load(input logic [NUM_W-1:0] q);
        logic [LOAD_W-1:0] r;
        r = (|q[NUM_W-1:LOAD_W]) ? LOAD_MAX : q[LOAD_W-1:0];
        return r;
    endfunction

endpackage

/* src/fsp_if.sv */
// fsp_if: stream interfaces for timestamps and pacing results
// depends on fsp_pkg

interface fsp_stamp_if;
    import fsp_pkg::*;

    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] now_ticks;

    modport source (output valid, output now_ticks, input ready);
    modport sink   (input valid, input now_ticks, output ready);
endinterface

interface fsp_verdict_if;
    import fsp_pkg::*;

    logic              valid;
    logic              ready;
    logic [DEC_W-1:0]  decision;
    logic [RATE_W-1:0] render_rate;
    logic [RATE_W-1:0] skip_rate;
    logic [LOAD_W-1:0] load_level;

    modport source (output valid, output decision, output render_rate,
                    output skip_rate, output load_level, input ready);
    modport sink   (input valid, input decision, input render_rate,
                    input skip_rate, input load_level, output ready);
endinterface

/* src/fsp_mul.sv */
// fsp_mul: shared 32x32 multiplier with registered product
// depends on fsp_pkg

module fsp_mul (
    input  logic                       clk,
    input  logic [fsp_pkg::MUL_W-1:0]  a,
    input  logic [fsp_pkg::MUL_W-1:0]  b,
    output logic [fsp_pkg::PROD_W-1:0] p
);
    import fsp_pkg::*;

    logic [PROD_W-1:0] p_reg;

    // one product per cycle, registered product on p in the next cycle
    always_ff @(posedge clk)
    begin
        p_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = p_reg;

endmodule

/* src/fsp_div.sv */
// fsp_div: restoring divider, one quotient bit per cycle
// depends on fsp_pkg

module fsp_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [fsp_pkg::NUM_W-1:0] num,
    input  logic [fsp_pkg::DEN_W-1:0] den,
    output fsp_pkg::fsp_div_stat_t    stat,
    output logic [fsp_pkg::NUM_W-1:0] quot
);
    import fsp_pkg::*;

    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              done_reg;

    logic [DEN_W:0]    rem_shift;
    logic [DEN_W:0]    rem_diff;
    logic              q_bit;

    // trial subtract of the shifted remainder
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[NUM_W-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};
        q_bit     = (rem_shift >= {1'b0, den_reg});
    end

    // iteration control and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            quo_reg  <= num;
            rem_reg  <= '0;
            den_reg  <= den;
            cnt_reg  <= DCNT_W'(NUM_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg  <= {quo_reg[NUM_W-2:0], q_bit};
            rem_reg  <= q_bit ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            cnt_reg  <= cnt_reg - DCNT_W'(1);
            done_reg <= (cnt_reg == DCNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quot      = quo_reg;

endmodule

/* src/frame_skip_pacer_core.sv */
// frame_skip_pacer_core: one result per timestamp; a window close adds serial divisions
// for the render and skip rates, and for the load when the window rendered anything;
// a new timestamp is taken only once the previous one has been processed, but
// the output register lets the next timestamp start while a result waits
// reset clears all counters and rates, sets load to 1.0 and config to 15 / 1000000
// depends on fsp_pkg, fsp_if, fsp_mul, fsp_div

module frame_skip_pacer_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [fsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fsp_pkg::CFG_DATA_W-1:0] cfg_data,
    fsp_stamp_if.sink                      stamp,
    fsp_verdict_if.source                  verdict
);
    import fsp_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP,
        ST_CHECK,
        ST_RR_MUL,
        ST_RR_DIV,
        ST_RR_WAIT,
        ST_SR_MUL,
        ST_SR_DIV,
        ST_SR_WAIT,
        ST_LD_MUL1,
        ST_LD_MUL2,
        ST_LD_DIV,
        ST_LD_WAIT,
        ST_WCLOSE,
        ST_D_M1,
        ST_D_M2,
        ST_D_M3,
        ST_D_M4,
        ST_D_M5,
        ST_D_M6,
        ST_D_M7,
        ST_D_M8,
        ST_D_DEC,
        ST_OUT
    } state_t;

    state_t             state_reg;

    // configuration
    logic [FPS_W-1:0]   fps_reg;
    logic [FREQ_W-1:0]  freq_reg;

    // pacing state
    logic [TIME_W-1:0]  now_reg;
    logic [TIME_W-1:0]  wstart_reg;
    logic [TIME_W-1:0]  prev_reg;
    logic [TIME_W-1:0]  busy_reg;
    logic [CNT_W-1:0]   rendered_reg;
    logic [CNT_W-1:0]   skipped_reg;
    logic [RUN_W-1:0]   skip_run_reg;
    fsp_decision_t      last_dec_reg;
    logic [RATE_W-1:0]  rr_reg;
    logic [RATE_W-1:0]  sr_reg;
    logic [LOAD_W-1:0]  load_reg;

    // working registers
    logic [TIME_W-1:0]  span_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic               lt_reg;
    logic [DEN_W-1:0]   lnum_reg;
    logic               zero_reg;

    // output register
    logic               out_valid_reg;
    fsp_decision_t      out_dec_reg;
    logic [RATE_W-1:0]  out_rr_reg;
    logic [RATE_W-1:0]  out_sr_reg;
    logic [LOAD_W-1:0]  out_load_reg;

    // shared units
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    fsp_div_stat_t      div_stat;
    logic [NUM_W-1:0]   div_quot;

    logic [TIME_W-1:0]  elapsed;
    logic [TIME_W:0]    busy_sum;
    logic               add_busy;
    logic               skip_tol;

    fsp_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    fsp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fps_reg  <= FPS_RESET;
            freq_reg <= FREQ_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (fsp_cfg_idx_t'(cfg_index))
                CFG_FPS:  fps_reg  <= cfg_data[FPS_W-1:0];
                CFG_FREQ: freq_reg <= cfg_data[FREQ_W-1:0];
                default:  ;
            endcase
        end
    end

    // busy time since the previous frame, saturating, and the skip tolerance compare
    always_comb
    begin
        elapsed  = now_reg - prev_reg;
        busy_sum = {1'b0, busy_reg} + {1'b0, elapsed};
        add_busy = (last_dec_reg != DEC_IDLE) && (now_reg >= prev_reg);
        skip_tol = (acc_reg < mul_p[ACC_W-1:0]);
    end

    // multiplier operand select per step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_RR_MUL:
            begin
                mul_a = MUL_W'(rendered_reg);
                mul_b = freq_reg;
            end
            ST_SR_MUL:
            begin
                mul_a = MUL_W'(skipped_reg);
                mul_b = freq_reg;
            end
            ST_LD_MUL1:
            begin
                mul_a = busy_reg;
                mul_b = MUL_W'(fps_reg);
            end
            ST_LD_MUL2:
            begin
                mul_a = span_reg;
                mul_b = MUL_W'(rendered_reg);
            end
            ST_D_M1:
            begin
                mul_a = MUL_W'(fps_reg);
                mul_b = K_FRAME_SCALE;
            end
            ST_D_M2:
            begin
                mul_a = span_reg;
                mul_b = mul_p[MUL_W-1:0];
            end
            ST_D_M3:
            begin
                mul_a = MUL_W'(load_reg);
                mul_b = K_LOAD_SCALE;
            end
            ST_D_M4:
            begin
                mul_a = mul_p[MUL_W-1:0];
                mul_b = freq_reg;
            end
            ST_D_M5:
            begin
                mul_a = MUL_W'(rendered_reg);
                mul_b = K_FRAME_SCALE;
            end
            ST_D_M6:
            begin
                mul_a = mul_p[MUL_W-1:0] + K_MARGIN;
                mul_b = freq_reg;
            end
            ST_D_M7:
            begin
                mul_a = span_reg;
                mul_b = MUL_W'(fps_reg);
            end
            ST_D_M8:
            begin
                mul_a = MUL_W'(total_reg) + MUL_W'(SKIP_TOLERANCE);
                mul_b = freq_reg;
            end
            default: ;
        endcase
    end

    // divider operand select
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = DEN_W'(span_reg);
        unique case (state_reg)
            ST_RR_DIV, ST_SR_DIV:
            begin
                div_start = 1'b1;
                div_num   = {mul_p[NUM_W-RATE_FRAC-1:0], {RATE_FRAC{1'b0}}};
            end
            ST_LD_DIV:
            begin
                div_start = 1'b1;
                div_num   = {lnum_reg, {LOAD_FRAC{1'b0}}};
                div_den   = mul_p[DEN_W-1:0];
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            wstart_reg    <= '0;
            prev_reg      <= '0;
            busy_reg      <= '0;
            rendered_reg  <= '0;
            skipped_reg   <= '0;
            skip_run_reg  <= '0;
            last_dec_reg  <= DEC_IDLE;
            rr_reg        <= '0;
            sr_reg        <= '0;
            load_reg      <= LOAD_RESET;
            span_reg      <= '0;
            total_reg     <= '0;
            acc_reg       <= '0;
            lt_reg        <= 1'b0;
            lnum_reg      <= '0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_dec_reg   <= DEC_IDLE;
            out_rr_reg    <= '0;
            out_sr_reg    <= '0;
            out_load_reg  <= '0;
        end
        else
        begin
            // result register drains unless a new result replaces it
            if (out_valid_reg && verdict.ready && state_reg != ST_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (stamp.valid)
                    begin
                        now_reg   <= stamp.now_ticks;
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    if (add_busy)
                    begin
                        busy_reg <= busy_sum[TIME_W] ? BUSY_MAX : busy_sum[TIME_W-1:0];
                    end
                    span_reg  <= (now_reg >= wstart_reg) ? now_reg - wstart_reg : '0;
                    total_reg <= TOTAL_W'(rendered_reg) + TOTAL_W'(skipped_reg);
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    if (total_reg >= TOTAL_W'(fps_reg))
                    begin
                        state_reg <= ST_RR_MUL;
                    end
                    else
                    begin
                        // backward time restarts an open window
                        if (now_reg < wstart_reg)
                        begin
                            wstart_reg <= now_reg;
                            span_reg   <= '0;
                        end
                        state_reg <= ST_D_M1;
                    end
                end
                ST_RR_MUL:
                begin
                    state_reg <= ST_RR_DIV;
                end
                ST_RR_DIV:
                begin
                    zero_reg  <= (mul_p == '0);
                    state_reg <= ST_RR_WAIT;
                end
                ST_RR_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        rr_reg    <= zero_reg ? '0 : sat_rate(div_quot);
                        state_reg <= ST_SR_MUL;
                    end
                end
                ST_SR_MUL:
                begin
                    state_reg <= ST_SR_DIV;
                end
                ST_SR_DIV:
                begin
                    zero_reg  <= (mul_p == '0);
                    state_reg <= ST_SR_WAIT;
                end
                ST_SR_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        sr_reg    <= zero_reg ? '0 : sat_rate(div_quot);
                        state_reg <= (rendered_reg != '0) ? ST_LD_MUL1 : ST_WCLOSE;
                    end
                end
                ST_LD_MUL1:
                begin
                    state_reg <= ST_LD_MUL2;
                end
                ST_LD_MUL2:
                begin
                    lnum_reg  <= mul_p[DEN_W-1:0];
                    state_reg <= ST_LD_DIV;
                end
                ST_LD_DIV:
                begin
                    zero_reg  <= (lnum_reg == '0);
                    state_reg <= ST_LD_WAIT;
                end
                ST_LD_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        load_reg  <= zero_reg ? '0 : sat_load(div_quot);
                        state_reg <= ST_WCLOSE;
                    end
                end
                ST_WCLOSE:
                begin
                    // open a new window at this frame
                    wstart_reg   <= now_reg;
                    rendered_reg <= '0;
                    skipped_reg  <= '0;
                    busy_reg     <= '0;
                    span_reg     <= '0;
                    state_reg    <= ST_D_M1;
                end
                ST_D_M1:
                begin
                    state_reg <= ST_D_M2;
                end
                ST_D_M2:
                begin
                    state_reg <= ST_D_M3;
                end
                ST_D_M3:
                begin
                    acc_reg   <= mul_p[ACC_W-1:0];
                    state_reg <= ST_D_M4;
                end
                ST_D_M4:
                begin
                    state_reg <= ST_D_M5;
                end
                ST_D_M5:
                begin
                    acc_reg   <= acc_reg + mul_p[ACC_W-1:0];
                    state_reg <= ST_D_M6;
                end
                ST_D_M6:
                begin
                    state_reg <= ST_D_M7;
                end
                ST_D_M7:
                begin
                    lt_reg    <= (acc_reg < mul_p[ACC_W-1:0]);
                    state_reg <= ST_D_M8;
                end
                ST_D_M8:
                begin
                    acc_reg   <= mul_p[ACC_W-1:0];
                    state_reg <= ST_D_DEC;
                end
                ST_D_DEC:
                begin
                    // idle, render or skip
                    prev_reg <= now_reg;
                    priority if (lt_reg)
                    begin
                        last_dec_reg <= DEC_IDLE;
                    end
                    else if (skip_run_reg >= RUN_W'(MAX_SKIP_RUN) || skip_tol)
                    begin
                        rendered_reg <= rendered_reg + CNT_W'(1);
                        skip_run_reg <= '0;
                        last_dec_reg <= DEC_RENDER;
                    end
                    else
                    begin
                        skipped_reg  <= skipped_reg + CNT_W'(1);
                        skip_run_reg <= skip_run_reg + RUN_W'(1);
                        last_dec_reg <= DEC_SKIP;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || verdict.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_dec_reg   <= last_dec_reg;
                        out_rr_reg    <= rr_reg;
                        out_sr_reg    <= sr_reg;
                        out_load_reg  <= load_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign stamp.ready         = (state_reg == ST_IDLE);
    assign verdict.valid       = out_valid_reg;
    assign verdict.decision    = out_dec_reg;
    assign verdict.render_rate = out_rr_reg;
    assign verdict.skip_rate   = out_sr_reg;
    assign verdict.load_level  = out_load_reg;

`ifndef SYNTHESIS
    // ready drops after a transfer while its item is processed
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (stamp.valid && stamp.ready) |=> !stamp.ready)
        else $error("timestamp taken while an item is in progress");

    // skip run never exceeds its limit
    a_skip_run_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_D_DEC && skip_run_reg >= RUN_W'(MAX_SKIP_RUN))
        |=> last_dec_reg != DEC_SKIP)
        else $error("skip issued beyond the allowed run");

    // divider is started only when free
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    // closing a window clears its counts
    a_window_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WCLOSE)
        |=> (rendered_reg == '0 && skipped_reg == '0 && busy_reg == '0))
        else $error("window counts not cleared");
`endif

endmodule

/* sim/tb_frame_skip_pacer_core.sv */
// tb_frame_skip_pacer_core: self-checking bench for the frame skip pacer
// drives timestamps through a scripted and a random phase, predicts each verdict
// depends on fsp_pkg, fsp_if and the frame_skip_pacer_core rtl

module tb_frame_skip_pacer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import fsp_pkg::*;

    // fixed point factors of the pacing rules
    localparam bit [63:0] FRAME_SCALE = 64'd81920;
    localparam bit [63:0] MARGIN      = 64'd45056;
    localparam bit [63:0] LOAD_SCALE  = 64'd10;
    localparam bit [63:0] RATE_SCALE  = 64'd256;
    localparam bit [63:0] LOAD_ONE    = 64'd4096;

    localparam int SCRIPT_LEN     = 24;
    localparam int SEGMENTS       = 8;
    localparam int ITEMS_PER_SEG  = 235;
    localparam int SETTLE_CYCLES  = 400;

    typedef struct packed {
        fsp_decision_t      decision;
        logic [RATE_W-1:0]  render_rate;
        logic [RATE_W-1:0]  skip_rate;
        logic [LOAD_W-1:0]  load_level;
    } verdict_t;

    typedef enum logic {
        ROW_STAMP = 1'b0,
        ROW_CFG   = 1'b1
    } row_kind_t;

    typedef struct {
        row_kind_t    kind;
        fsp_cfg_idx_t idx;
        logic [31:0]  value;
        bit           typed;
        verdict_t     want;
    } script_row_t;

    localparam verdict_t NO_VERDICT = '0;

    // scripted opening: reset state, extremes, backward time, config corners
    script_row_t script_rows [SCRIPT_LEN] = '{
        '{ROW_STAMP, CFG_FPS,  32'h0000_0000, 1'b1, '{DEC_IDLE,   24'd0, 24'd0, 16'd4096}},
        '{ROW_STAMP, CFG_FPS,  32'hFFFF_FFFF, 1'b1, '{DEC_SKIP,   24'd0, 24'd0, 16'd4096}},
        '{ROW_STAMP, CFG_FPS,  32'hFFFF_FFFF, 1'b1, '{DEC_RENDER, 24'd0, 24'd0, 16'd4096}},
        '{ROW_STAMP, CFG_FPS,  32'h0000_0000, 1'b0, NO_VERDICT},
        '{ROW_STAMP, CFG_FPS,  32'hF000_0000, 1'b0, NO_VERDICT},
        '{ROW_STAMP, CFG_FPS,  32'h0000_0010, 1'b0, NO_VERDICT},
        '{ROW_STAMP, CFG_FPS,  32'hF000_0010, 1'b0, NO_VERDICT},
        '{ROW_STAMP, CFG_FPS,  32'h0000_0020, 1'b0, NO_VERDICT},
        '{ROW_CFG,   CFG_FPS,  32'd1,         1'b0, NO_VERDICT},
        '{ROW_STAMP, CFG_FPS,  32'd5000,      1'b0, NO_VERDICT},
        '{ROW_STAMP, CFG_FPS,  32'd5000,      1'b0, NO_VERDICT},
        '{ROW_STAMP, CFG_FPS,  32'd0,         1'b0, NO_VERDICT},
        '{ROW_STAMP, CFG_FPS,  32'h7FFF_FFFF, 1'b0, NO_VERDICT},
        '{ROW_CFG,   CFG_FREQ, 32'd0,         1'b0, NO_VERDICT},
        '{ROW_STAMP, CFG_FPS,  32'd100,       1'b0, NO_VERDICT},
        '{ROW_STAMP, CFG_FPS,  32'd200,       1'b0, NO_VERDICT},
        '{ROW_CFG,   CFG_FPS,  32'd0,         1'b0, NO_VERDICT},
        '{ROW_STAMP, CFG_FPS,  32'd300,       1'b0, NO_VERDICT},
        '{ROW_STAMP, CFG_FPS,  32'd300,       1'b0, NO_VERDICT},
        '{ROW_CFG,   CFG_FREQ, 32'hFFFF_FFFF, 1'b0, NO_VERDICT},
        '{ROW_CFG,   CFG_FPS,  32'd255,       1'b0, NO_VERDICT},
        '{ROW_STAMP, CFG_FPS,  32'h1234_5678, 1'b0, NO_VERDICT},
        '{ROW_STAMP, CFG_FPS,  32'hAAAA_AAAA, 1'b0, NO_VERDICT},
        '{ROW_STAMP, CFG_FPS,  32'h5555_5555, 1'b0, NO_VERDICT}
    };

    // register settings of the random segments
    logic [FPS_W-1:0]  seg_fps  [SEGMENTS] = '{8'd30, 8'd1, 8'd255, 8'd15,
                                               8'd0, 8'd60, 8'd1, 8'd24};
    logic [FREQ_W-1:0] seg_freq [SEGMENTS] = '{32'd1000000, 32'd1000, 32'hFFFF_FFFF, 32'd0,
                                               32'd90000, 32'd1, 32'hFFFF_FFFF, 32'd48000};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    fsp_stamp_if   stamp_ch ();
    fsp_verdict_if verdict_ch ();

    frame_skip_pacer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stamp     (stamp_ch),
        .verdict   (verdict_ch)
    );

    always #1 clk = ~clk;

    // pacer state mirror
    logic [FPS_W-1:0]   fps_q;
    logic [FREQ_W-1:0]  freq_q;
    logic [TIME_W-1:0]  win_start_q;
    logic [TIME_W-1:0]  prev_stamp_q;
    logic [31:0]        busy_q;
    logic [CNT_W-1:0]   rendered_q;
    logic [CNT_W-1:0]   skipped_q;
    logic [RUN_W-1:0]   skip_run_q;
    fsp_decision_t      last_dec_q;
    logic [RATE_W-1:0]  render_rate_q;
    logic [RATE_W-1:0]  skip_rate_q;
    logic [LOAD_W-1:0]  load_q;

    verdict_t pending_verdicts [$];
    verdict_t seen;
    verdict_t due;

    int send_idle_pct = 23;
    int recv_idle_pct = 57;
    int fault_count = 0;
    int stamps_sent = 0;
    int verdicts_checked = 0;
    int windows_closed = 0;
    int settings_used = 1;
    int decision_tally [4] = '{0, 0, 0, 0};

    // quotient clamped to a field maximum, zero divisor saturates unless the dividend is zero
    function automatic bit [63:0] clamp_quotient(input bit [63:0] num, input bit [63:0] den,
                                                 input bit [63:0] lim);
        bit [63:0] q;
        if (den == 64'd0)
            return (num != 64'd0) ? lim : 64'd0;
        q = num / den;
        return (q > lim) ? lim : q;
    endfunction

    // advance the mirror by one timestamp and return the verdict it yields
    function automatic verdict_t pace_frame(input logic [TIME_W-1:0] now);
        bit [63:0] t;
        bit [63:0] span;
        bit [63:0] total;
        bit [63:0] fps;
        bit [63:0] freq;
        bit [63:0] busy_sum;
        bit [63:0] lhs;
        bit [63:0] rhs;
        verdict_t  res;
        t = 64'(now);
        fps = 64'(fps_q);
        freq = 64'(freq_q);

        // time after a render or skip counts as busy
        if (last_dec_q == DEC_RENDER || last_dec_q == DEC_SKIP) begin
            if (now >= prev_stamp_q) begin
                busy_sum = 64'(busy_q) + t - 64'(prev_stamp_q);
                busy_q = (busy_sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : busy_sum[31:0];
            end
        end

        span = (now >= win_start_q) ? t - 64'(win_start_q) : 64'd0;
        total = 64'(rendered_q) + 64'(skipped_q);

        // window end: rates and, after any render, load, then a fresh window; backward time restarts it
        if (total >= fps) begin
            render_rate_q = RATE_W'(clamp_quotient(64'(rendered_q) * freq * RATE_SCALE,
                                                   span, 64'(RATE_MAX)));
            skip_rate_q = RATE_W'(clamp_quotient(64'(skipped_q) * freq * RATE_SCALE,
                                                 span, 64'(RATE_MAX)));
            if (rendered_q != '0)
                load_q = LOAD_W'(clamp_quotient(64'(busy_q) * fps * LOAD_ONE,
                                                span * 64'(rendered_q), 64'(LOAD_MAX)));
            win_start_q = now;
            rendered_q = '0;
            skipped_q = '0;
            busy_q = '0;
            span = 64'd0;
            windows_closed++;
        end else if (now < win_start_q) begin
            win_start_q = now;
            span = 64'd0;
        end

        prev_stamp_q = now;

        // idle unless the frame is due, skip only with enough backlog
        lhs = span * fps * FRAME_SCALE + LOAD_SCALE * 64'(load_q) * freq;
        rhs = 64'(rendered_q) * freq * FRAME_SCALE + MARGIN * freq;
        if (lhs < rhs) begin
            res.decision = DEC_IDLE;
        end else if (skip_run_q >= MAX_SKIP_RUN ||
                     span * fps < (total + 64'(SKIP_TOLERANCE)) * freq) begin
            rendered_q = rendered_q + CNT_W'(1);
            skip_run_q = '0;
            res.decision = DEC_RENDER;
        end else begin
            skipped_q = skipped_q + CNT_W'(1);
            if (skip_run_q < MAX_SKIP_RUN)
                skip_run_q = skip_run_q + RUN_W'(1);
            res.decision = DEC_SKIP;
        end

        last_dec_q = res.decision;
        res.render_rate = render_rate_q;
        res.skip_rate = skip_rate_q;
        res.load_level = load_q;
        return res;
    endfunction

    // next timestamp: mostly paced frames, with stalls, jumps back and noise
    function automatic logic [31:0] next_stamp(input logic [31:0] prev, input bit [63:0] period);
        int        pick;
        bit [63:0] step;
        pick = $urandom_range(99);
        if (pick < 65) begin
            step = period * $urandom_range(40, 4) / 16;
            return prev + step[31:0];
        end else if (pick < 73) begin
            return prev + $urandom_range(3);
        end else if (pick < 80) begin
            return prev - $urandom_range(1 << 20, 1);
        end else if (pick < 86) begin
            return $urandom;
        end else if (pick < 90) begin
            return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        end else if (pick < 95) begin
            return prev ^ 32'hF000_0000;
        end
        return prev;
    endfunction

    // one timestamp transfer, with random gaps ahead of it
    task automatic send_stamp(input logic [31:0] t, input bit typed, input verdict_t want);
        verdict_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            stamp_ch.valid <= 1'b0;
            @(posedge clk);
        end
        stamp_ch.valid <= 1'b1;
        stamp_ch.now_ticks <= t;
        do
            @(posedge clk);
        while (!stamp_ch.ready);
        predicted = pace_frame(t);
        pending_verdicts.push_back(typed ? want : predicted);
        stamps_sent++;
    endtask

    // stop sending and wait until every verdict has come back
    task automatic drain;
        stamp_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // single register write, wen dropped on the following cycle
    task automatic write_reg(input fsp_cfg_idx_t idx, input logic [31:0] value);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        @(posedge clk);
        if (idx == CFG_FPS)
            fps_q = value[FPS_W-1:0];
        else
            freq_q = value;
        settings_used++;
    endtask

    // receiver: random back-pressure and verdict checking
    always @(posedge clk) begin
        if (!rst_n) begin
            verdict_ch.ready <= 1'b0;
        end else begin
            verdict_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            if (verdict_ch.valid && verdict_ch.ready) begin
                seen.decision = fsp_decision_t'(verdict_ch.decision);
                seen.render_rate = verdict_ch.render_rate;
                seen.skip_rate = verdict_ch.skip_rate;
                seen.load_level = verdict_ch.load_level;
                if (pending_verdicts.size() == 0) begin
                    fault_count++;
                    $error("verdict with none pending: decision %0d", seen.decision);
                end else begin
                    due = pending_verdicts.pop_front();
                    verdicts_checked++;
                    decision_tally[seen.decision]++;
                    if (seen != due) begin
                        fault_count++;
                        if (seen.decision != due.decision)
                            $error("decision: expected %0d, got %0d",
                                   due.decision, seen.decision);
                        if (seen.render_rate != due.render_rate)
                            $error("render_rate: expected %0d, got %0d",
                                   due.render_rate, seen.render_rate);
                        if (seen.skip_rate != due.skip_rate)
                            $error("skip_rate: expected %0d, got %0d",
                                   due.skip_rate, seen.skip_rate);
                        if (seen.load_level != due.load_level)
                            $error("load_level: expected %0d, got %0d",
                                   due.load_level, seen.load_level);
                    end
                end
            end
        end
    end

    // stimulus
    initial begin
        logic [31:0] last_t;
        bit   [63:0] period;

        rst_n = 1'b0;
        cfg_wen = 1'b0;
        cfg_index = CFG_FPS;
        cfg_data = '0;
        stamp_ch.valid = 1'b0;
        stamp_ch.now_ticks = '0;

        // mirror starts in the reset state
        fps_q = FPS_RESET;
        freq_q = FREQ_RESET;
        win_start_q = '0;
        prev_stamp_q = '0;
        busy_q = '0;
        rendered_q = '0;
        skipped_q = '0;
        skip_run_q = '0;
        last_dec_q = DEC_IDLE;
        render_rate_q = '0;
        skip_rate_q = '0;
        load_q = LOAD_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // scripted part
        foreach (script_rows[i]) begin
            if (script_rows[i].kind == ROW_CFG) begin
                drain();
                write_reg(script_rows[i].idx, script_rows[i].value);
            end else begin
                send_stamp(script_rows[i].value, script_rows[i].typed, script_rows[i].want);
            end
        end

        // random segments, each with its own fps and freq setting
        last_t = 32'h0000_0000;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain();
            write_reg(CFG_FPS, 32'(seg_fps[seg]));
            write_reg(CFG_FREQ, seg_freq[seg]);
            if (seg < 3) begin
                send_idle_pct = 23;
                recv_idle_pct = 57;
            end else if (seg < 6) begin
                send_idle_pct = 57;
                recv_idle_pct = 23;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            period = (seg_fps[seg] == '0) ? 64'(seg_freq[seg])
                                          : 64'(seg_freq[seg]) / 64'(seg_fps[seg]);
            if (period == 64'd0)
                period = 64'd1;
            for (int n = 0; n < ITEMS_PER_SEG; n++) begin
                last_t = next_stamp(last_t, period);
                send_stamp(last_t, 1'b0, NO_VERDICT);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d timestamps sent under %0d register settings, %0d windows closed",
                 stamps_sent, settings_used, windows_closed);
        $display("%0d verdicts checked: %0d idle, %0d render, %0d skip",
                 verdicts_checked, decision_tally[DEC_IDLE], decision_tally[DEC_RENDER],
                 decision_tally[DEC_SKIP]);
        if (fault_count == 0 && pending_verdicts.size() == 0)
            $display("frame_skip_pacer_core test passed");
        else
            $display("frame_skip_pacer_core test failed");
        $finish;
    end

    // watchdog
    initial begin
        #6_000_000;
        $display("frame_skip_pacer_core test failed");
        $finish;
    end

endmodule

/* sim.f */
src/fsp_pkg.sv
src/fsp_if.sv
src/fsp_mul.sv
src/fsp_div.sv
src/frame_skip_pacer_core.sv
sim/tb_frame_skip_pacer_core.sv
